FILE: rtl/core/bae_pkg.sv
package bae_pkg;

  // fixed field widths
  localparam int unsigned IDX_W     = 12;
  localparam int unsigned LEN_W     = 13;
  localparam int unsigned CMD_W     = 3;
  localparam logic [12:0] LEN_RESET = 13'd4096;

  // command codes
  typedef enum logic [2:0] {
    CMD_GET       = 3'd0,
    CMD_SET       = 3'd1,
    CMD_CLR       = 3'd2,
    CMD_SET_RANGE = 3'd3,
    CMD_CLR_RANGE = 3'd4,
    CMD_CLR_ALL   = 3'd5,
    CMD_FIND      = 3'd6
  } cmd_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_WALK  = 2'd2
  } state_t;

endpackage

FILE: rtl/core/bitmap_allocation_engine_unit.sv
// channel   | signals                                   | transfer
// ----------+-------------------------------------------+---------------------------
// command   | start, busy, cmd, index_low, index_high   | start high while busy low
// result    | done, bit_value, found, found_index, error| done high, one cycle only
// config    | cfg_valid, cfg_ready, bits_in_use         | cfg_valid and cfg_ready high
//
// Single-bit and range commands walk the word store from word 0 up to the word holding
// the last bit touched; find walks up to the word holding bit length - 1 and stops early
// at a hit; clear all writes every word to zero; a rejected command answers in the cycle
// after it is taken. The walk goes word by word through the one read and one write port
// of the word memory and the one shared mask unit. After reset a clearing pass writes
// every word to zero with busy high. done is high for one cycle only, the result values
// hold until the next result, and the receiver cannot stall.
module bitmap_allocation_engine_unit #(
  parameter int unsigned MAX_BITS  = 4096,
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  // command
  input  logic                          start,
  output logic                          busy,
  input  logic [bae_pkg::CMD_W-1:0]     cmd,
  input  logic [bae_pkg::IDX_W-1:0]     index_low,
  input  logic [bae_pkg::IDX_W-1:0]     index_high,
  // result
  output logic                          done,
  output logic                          bit_value,
  output logic                          found,
  output logic [bae_pkg::IDX_W-1:0]     found_index,
  output logic                          error,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bae_pkg::LEN_W-1:0]     bits_in_use
);

  localparam int unsigned NWORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int unsigned CNT_W  = $clog2(NWORDS + 1);
  localparam int unsigned BASE_W = $clog2(NWORDS * WORD_BITS + 1) + 1;
  localparam int unsigned CMP_W  =
    ((BASE_W > bae_pkg::LEN_W) ? BASE_W : bae_pkg::LEN_W) + 1;
  localparam int unsigned OFF_W  = $clog2(WORD_BITS);

  typedef logic [WORD_BITS-1:0] word_t;

  // lowest set bit of a word
  function automatic logic [OFF_W-1:0] lowest_set(input word_t v);
    logic [OFF_W-1:0] r;
    r = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (v[j]) begin
        r = OFF_W'(j);
      end
    end
    return r;
  endfunction

  bae_pkg::state_t state, state_next;

  logic [bae_pkg::LEN_W-1:0] len_cfg;
  logic [bae_pkg::LEN_W-1:0] len_eff;
  bae_pkg::cmd_t             cmd_q;
  logic [bae_pkg::LEN_W-1:0] lo_q;
  logic [bae_pkg::LEN_W-1:0] hi_q;
  logic                      clr_cmd;
  logic [CNT_W-1:0]          addr_cnt;
  logic [BASE_W-1:0]         iss_base;
  logic                      stg_valid;
  logic [AW-1:0]             stg_addr;
  logic [BASE_W-1:0]         stg_base;

  // word memory
  word_t                     mem [0:NWORDS-1];
  word_t                     rdata;
  logic                      mem_we;
  logic                      mem_re;
  logic [AW-1:0]             mem_waddr;
  word_t                     mem_wdata;

  // command decode
  bae_pkg::cmd_t             cmd_in;
  logic                      accept;
  logic                      acc_err;
  logic                      acc_empty;

  // mask unit
  logic [CMP_W-1:0]          b_x, lo_x, hi_x, lo_d, hi_d, fidx_sum;
  logic [OFF_W-1:0]          hi_cl;
  logic [OFF_W-1:0]          pos;
  logic                      lo_in, hi_in, hi_end;
  word_t                     mask, cand;
  logic                      hit;

  // sequencer outputs
  logic                      walk_finish;
  logic                      clr_last;
  logic                      is_write;
  logic                      is_set;

  assign cfg_ready = 1'b1;
  assign busy      = (state != bae_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign cmd_in    = bae_pkg::cmd_t'(cmd);

  // length in use, capped at the store size
  always_comb begin
    if (32'(len_cfg) > MAX_BITS) begin
      len_eff = bae_pkg::LEN_W'(MAX_BITS);
    end else begin
      len_eff = len_cfg;
    end
  end

  // argument checks at command transfer
  always_comb begin
    acc_err   = 1'b0;
    acc_empty = 1'b0;
    unique case (cmd_in)
      bae_pkg::CMD_GET, bae_pkg::CMD_SET, bae_pkg::CMD_CLR: begin
        acc_err = ({1'b0, index_low} >= len_eff);
      end
      bae_pkg::CMD_SET_RANGE, bae_pkg::CMD_CLR_RANGE: begin
        acc_err = ({1'b0, index_high} >= len_eff) || (index_low > index_high);
      end
      bae_pkg::CMD_CLR_ALL: begin
        acc_err = 1'b0;
      end
      bae_pkg::CMD_FIND: begin
        acc_empty = (len_eff == '0);
      end
      default: begin
        acc_err = 1'b1;
      end
    endcase
  end

  // bit mask of the current word that lies inside lo..hi
  always_comb begin
    b_x    = CMP_W'(stg_base);
    lo_x   = CMP_W'(lo_q);
    hi_x   = CMP_W'(hi_q);
    lo_d   = (lo_x > b_x) ? (lo_x - b_x) : '0;
    lo_in  = (lo_d < CMP_W'(WORD_BITS));
    hi_in  = (hi_x >= b_x);
    hi_d   = hi_x - b_x;
    hi_cl  = (hi_d >= CMP_W'(WORD_BITS)) ? OFF_W'(WORD_BITS - 1) : hi_d[OFF_W-1:0];
    hi_end = (hi_x < (b_x + CMP_W'(WORD_BITS)));
    if (lo_in && hi_in) begin
      mask = ({WORD_BITS{1'b1}} << lo_d[OFF_W-1:0]) &
             ({WORD_BITS{1'b1}} >> (OFF_W'(WORD_BITS - 1) - hi_cl));
    end else begin
      mask = '0;
    end
    cand     = ~rdata & mask;
    hit      = |cand;
    pos      = lowest_set(cand);
    fidx_sum = b_x + CMP_W'(pos);
  end

  assign is_set   = (cmd_q == bae_pkg::CMD_SET) || (cmd_q == bae_pkg::CMD_SET_RANGE);
  assign is_write = is_set || (cmd_q == bae_pkg::CMD_CLR) ||
                    (cmd_q == bae_pkg::CMD_CLR_RANGE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bae_pkg::ST_CLEAR: begin
        if (clr_last) begin
          state_next = bae_pkg::ST_IDLE;
        end
      end
      bae_pkg::ST_IDLE: begin
        if (accept && !acc_err && !acc_empty) begin
          if (cmd_in == bae_pkg::CMD_CLR_ALL) begin
            state_next = bae_pkg::ST_CLEAR;
          end else begin
            state_next = bae_pkg::ST_WALK;
          end
        end
      end
      bae_pkg::ST_WALK: begin
        if (walk_finish) begin
          state_next = bae_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bae_pkg::ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = stg_addr;
    mem_wdata   = is_set ? (rdata | mask) : (rdata & ~mask);
    walk_finish = 1'b0;
    clr_last    = 1'b0;
    unique case (state)
      bae_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = addr_cnt[AW-1:0];
        mem_wdata = '0;
        clr_last  = (addr_cnt == CNT_W'(NWORDS - 1));
      end
      bae_pkg::ST_IDLE: begin
        mem_we = 1'b0;
      end
      bae_pkg::ST_WALK: begin
        mem_re      = (addr_cnt < CNT_W'(NWORDS));
        mem_we      = stg_valid && is_write;
        walk_finish = stg_valid && (hi_end || ((cmd_q == bae_pkg::CMD_FIND) && hit));
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // word memory ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[addr_cnt[AW-1:0]];
    end
  end

  // state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= bae_pkg::ST_CLEAR;
      len_cfg <= bae_pkg::LEN_RESET;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        len_cfg <= bits_in_use;
      end
    end
  end

  // word walk and clearing counters
  always_ff @(posedge clk) begin
    if (rst) begin
      addr_cnt  <= '0;
      stg_valid <= 1'b0;
      clr_cmd   <= 1'b0;
    end else begin
      unique case (state)
        bae_pkg::ST_CLEAR: begin
          addr_cnt <= addr_cnt + 1'b1;
        end
        bae_pkg::ST_IDLE: begin
          addr_cnt  <= '0;
          iss_base  <= '0;
          stg_valid <= 1'b0;
          if (accept) begin
            cmd_q   <= cmd_in;
            clr_cmd <= (cmd_in == bae_pkg::CMD_CLR_ALL);
            if (cmd_in == bae_pkg::CMD_FIND) begin
              lo_q <= '0;
              hi_q <= len_eff - 1'b1;
            end else if ((cmd_in == bae_pkg::CMD_SET_RANGE) ||
                         (cmd_in == bae_pkg::CMD_CLR_RANGE)) begin
              lo_q <= {1'b0, index_low};
              hi_q <= {1'b0, index_high};
            end else begin
              lo_q <= {1'b0, index_low};
              hi_q <= {1'b0, index_low};
            end
          end
        end
        bae_pkg::ST_WALK: begin
          stg_valid <= mem_re && !walk_finish;
          stg_addr  <= addr_cnt[AW-1:0];
          stg_base  <= iss_base;
          if (mem_re) begin
            addr_cnt <= addr_cnt + 1'b1;
            iss_base <= iss_base + BASE_W'(WORD_BITS);
          end
        end
        default: begin
          stg_valid <= 1'b0;
        end
      endcase
    end
  end

  // result registers and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (accept && (acc_err || acc_empty)) begin
        done        <= 1'b1;
        bit_value   <= 1'b0;
        found       <= 1'b0;
        found_index <= '0;
        error       <= acc_err;
      end else if ((state == bae_pkg::ST_CLEAR) && clr_last && clr_cmd) begin
        done        <= 1'b1;
        bit_value   <= 1'b0;
        found       <= 1'b0;
        found_index <= '0;
        error       <= 1'b0;
      end else if ((state == bae_pkg::ST_WALK) && walk_finish) begin
        done        <= 1'b1;
        bit_value   <= (cmd_q == bae_pkg::CMD_GET) && |(rdata & mask);
        found       <= (cmd_q == bae_pkg::CMD_FIND) && hit;
        found_index <= ((cmd_q == bae_pkg::CMD_FIND) && hit) ?
                       fidx_sum[bae_pkg::IDX_W-1:0] : '0;
        error       <= 1'b0;
      end
    end
  end

endmodule
